// ===== sv/crrt_pkg.sv =====
package crrt_pkg;

  localparam int RingDepthDefault = 256;
  localparam int SumWidth = 20;
  localparam logic [SumWidth-1:0] SumMax = '1;

  localparam logic [2:0] CMD_INS_POSTED = 3'd0;
  localparam logic [2:0] CMD_INS_ORPHAN = 3'd1;
  localparam logic [2:0] CMD_SET_TIME   = 3'd2;
  localparam logic [2:0] CMD_RELEASE    = 3'd3;
  localparam logic [2:0] CMD_SWEEP      = 3'd4;
  localparam logic [2:0] CMD_QUERY      = 3'd5;

  localparam logic CFG_TS_ENABLE = 1'b0;
  localparam logic CFG_FIRST_ID  = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] record_id;
    logic [11:0] posted_requests;
    logic        signaled_tail;
    logic [15:0] callback_tag;
    logic [15:0] batch_count;
    logic [47:0] byte_total;
    logic [47:0] post_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] assigned_id;
    logic        found;
    logic        overwrite_flag;
    logic [15:0] tag_out;
    logic [15:0] batch_out;
    logic [47:0] bytes_out;
    logic [47:0] time_out;
    logic [19:0] released_requests;
    logic        orphan_present;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;   // capture accepted item
    logic rd_issue;    // read slot at item index
    logic apply;       // modify-write slot from read data, build result
    logic scan_rd;     // read slot at scan index
    logic scan_step;   // evaluate scan read data
    logic scan_start;  // clear scan accumulators
    logic finish_scan; // build scan result
    logic out_take;    // result transferred
  } crrt_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_full;
    logic is_scan;
    logic clearing;
  } crrt_stat_t;

endpackage

// ===== sv/crrt_ctrl.sv =====
module crrt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_stall,
  input  crrt_pkg::crrt_stat_t stat,
  output crrt_pkg::crrt_cmd_t  cmd
);
  import crrt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_SCAN_END = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic accept;

  assign in_stall = (state_r != ST_IDLE) || stat.out_full || stat.clearing;
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    cmd.out_take = stat.out_full && !out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (stat.is_scan) begin
          cmd.scan_start = 1'b1;
          cmd.scan_rd = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_rd = !stat.scan_last;
        if (stat.scan_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        cmd.finish_scan = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== sv/crrt_dp.sv =====
module crrt_dp #(
  parameter int RING_DEPTH = crrt_pkg::RingDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crrt_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  crrt_pkg::crrt_cmd_t  cmd,
  output crrt_pkg::crrt_stat_t stat,
  output crrt_pkg::out_item_t  out_data,
  output logic                 out_valid
);
  import crrt_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  typedef struct packed {
    logic [11:0] req;
    logic [1:0]  flags;
    logic [15:0] tag;
    logic [15:0] batch;
    logic [47:0] bytes;
    logic [47:0] ptime;
  } slot_t;

  // Ids are kept in a memory; a slot is live when its id is nonzero. Every id is
  // cleared by a pass over the slots after reset.
  logic [31:0] id_mem [RING_DEPTH];
  slot_t       slot_mem [RING_DEPTH];

  in_item_t    item_r;
  logic        ts_en_r;
  logic [31:0] id_ctr_r;
  logic [31:0] rd_id_r;
  slot_t       rd_slot_r;
  logic [AW-1:0] rd_addr_r;
  logic [AW-1:0] scan_idx_r;
  logic [AW-1:0] clr_idx_r;
  logic        clearing_r;
  logic [20:0] sum_r;
  logic        orph_r;
  out_item_t   out_r;
  logic        out_full_r;

  logic        is_ins;
  logic [AW-1:0] item_addr;
  logic [AW-1:0] scan_addr;
  logic        live;
  logic        orphan_live;
  logic [20:0] sum_add;
  logic [31:0] id_inc;
  slot_t       wr_slot;
  out_item_t   res;
  logic        id_we, slot_we, clr_we;
  logic [31:0] id_wdata;

  assign is_ins = item_r.command == CMD_INS_POSTED || item_r.command == CMD_INS_ORPHAN;
  assign item_addr = is_ins ? id_ctr_r[AW-1:0] : item_r.record_id[AW-1:0];
  assign scan_addr = cmd.scan_start ? '0 : scan_idx_r + AW'(1);
  assign live = rd_id_r != 32'd0;
  assign orphan_live = live && rd_slot_r.flags[1];
  assign sum_add = sum_r + (orphan_live ? {9'd0, rd_slot_r.req} : 21'd0);
  assign id_inc = (id_ctr_r == '1) ? 32'd1 : id_ctr_r + 32'd1;

  assign stat.scan_last = scan_idx_r == AW'(RING_DEPTH - 1);
  assign stat.out_full = out_full_r;
  assign stat.is_scan = item_r.command == CMD_SWEEP || item_r.command == CMD_QUERY;
  assign stat.clearing = clearing_r;

  always_comb begin
    res = '0;
    wr_slot = rd_slot_r;
    id_we = 1'b0;
    slot_we = 1'b0;
    id_wdata = 32'd0;
    case (item_r.command)
      CMD_INS_POSTED, CMD_INS_ORPHAN: begin
        res.assigned_id = id_ctr_r;
        res.overwrite_flag = live;
        id_we = 1'b1;
        slot_we = 1'b1;
        id_wdata = id_ctr_r;
        wr_slot.req = item_r.posted_requests;
        wr_slot.flags = (item_r.command == CMD_INS_ORPHAN) ? 2'b10
                                                           : {1'b0, item_r.signaled_tail};
        wr_slot.tag = item_r.callback_tag;
        wr_slot.batch = item_r.batch_count;
        wr_slot.bytes = item_r.byte_total;
        wr_slot.ptime = 48'd0;
      end
      CMD_SET_TIME: begin
        if (ts_en_r && live && rd_id_r == item_r.record_id) begin
          res.found = 1'b1;
          slot_we = 1'b1;
          wr_slot.ptime = item_r.post_time;
        end
      end
      CMD_RELEASE: begin
        if (live && rd_id_r == item_r.record_id) begin
          res.found = 1'b1;
          res.tag_out = rd_slot_r.tag;
          res.batch_out = rd_slot_r.batch;
          res.bytes_out = rd_slot_r.bytes;
          res.time_out = rd_slot_r.ptime;
          res.released_requests = {8'd0, rd_slot_r.req};
          id_we = 1'b1;
        end
      end
      CMD_SWEEP: res.released_requests = sum_r[19:0];
      CMD_QUERY: res.orphan_present = orph_r;
      default: ;
    endcase
  end

  // During a sweep, the slot read in the previous cycle has its id cleared here if it holds a live orphan record.
  assign clr_we = cmd.scan_step && item_r.command == CMD_SWEEP && orphan_live;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_id_r <= id_mem[item_addr];
      rd_slot_r <= slot_mem[item_addr];
      rd_addr_r <= item_addr;
    end else if (cmd.scan_rd) begin
      rd_id_r <= id_mem[scan_addr];
      rd_slot_r <= slot_mem[scan_addr];
      rd_addr_r <= scan_addr;
    end
    if (clearing_r) id_mem[clr_idx_r] <= 32'd0;
    else if (cmd.apply && id_we) id_mem[rd_addr_r] <= id_wdata;
    else if (clr_we) id_mem[rd_addr_r] <= 32'd0;
    if (cmd.apply && slot_we) slot_mem[rd_addr_r] <= wr_slot;
    if (cmd.load_item) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r <= '0;
      ts_en_r <= 1'b0;
      id_ctr_r <= 32'd1;
      out_full_r <= 1'b0;
      scan_idx_r <= '0;
      sum_r <= '0;
      orph_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(RING_DEPTH - 1)) clearing_r <= 1'b0;
      end
      if (cfg_we && cfg_index == CFG_TS_ENABLE) ts_en_r <= cfg_wdata[0];
      if (cfg_we && cfg_index == CFG_FIRST_ID) begin
        id_ctr_r <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
      end else if (cmd.apply && is_ins) begin
        id_ctr_r <= id_inc;
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        sum_r <= '0;
        orph_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + AW'(1);
        sum_r <= sum_add[20] ? 21'(SumMax) : sum_add;
        orph_r <= orph_r | orphan_live;
      end
      if (cmd.apply || cmd.finish_scan) out_full_r <= 1'b1;
      else if (cmd.out_take) out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply || cmd.finish_scan) out_r <= res;
  end

  assign out_data = out_r;
  assign out_valid = out_full_r;

endmodule

// ===== sv/completion_record_ring_table_top.sv =====
// An insert, timestamp or release reads its slot in state READ and registers its result in state APPLY.
// Sweep and query read every slot in turn through the single slot memory port, then build their result.
// One item at a time: the next item is taken the cycle after the result transfer.
// Reset (rst_n, synchronous) turns timestamping off and loads the id counter with 1; after it,
// every slot is emptied by a pass over the slots during which the input is stalled.
module completion_record_ring_table_top #(
  parameter int RING_DEPTH = crrt_pkg::RingDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crrt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crrt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import crrt_pkg::*;

  crrt_cmd_t  cmd;
  crrt_stat_t stat;

  crrt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .stat, .cmd
  );

  crrt_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk, .rst_n, .in_data, .cfg_we, .cfg_index, .cfg_wdata,
    .cmd, .stat, .out_data, .out_valid
  );

endmodule

// ===== sv/crrt_checker.sv =====
module crrt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input crrt_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_stall
);
  import crrt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result appeared too early");

  a_id_zero_unused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overwrite_flag |-> out_data.assigned_id != 32'd0)
    else $error("overwrite without assigned id");

endmodule

bind completion_record_ring_table_top crrt_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_data, .out_valid, .out_stall
);
